// ===== sv/rcsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsa_pkg
// Request and status codes and default sizes of the slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

    localparam int SLOTS_PER_PAGE_DEF = 32;
    localparam int PAGES_DEF          = 4;
    localparam int COUNT_BITS_DEF     = 8;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_DROP  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_BUSY = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage

// ===== sv/rcsa_first_zero.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsa_first_zero
// Lowest clear bit of a vector: isolate it with one add, then encode.
// ----------------------------------------------------------------------------
module rcsa_first_zero #(
    parameter int W = 32
) (
    input  logic [W-1:0]                 bits,
    output logic                         found,
    output logic [(W > 1 ? $clog2(W) : 1)-1:0] index
);

    localparam int IW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0] free_bits;
    logic [W-1:0] lowest;

    assign free_bits = ~bits;
    assign lowest    = free_bits & (~free_bits + W'(1));
    assign found     = |free_bits;

    // one-hot to binary: OR in the index of the single set bit
    always_comb
    begin
        index = '0;
        for (int i = 0; i < W; i++)
        begin
            if (lowest[i])
            begin
                index = index | IW'(i);
            end
        end
    end

endmodule

// ===== sv/refcounted_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_unit
// Reference-counted slot pool with allocate, add-reference and drop-reference.
// ----------------------------------------------------------------------------
// In a request's accept cycle the unit picks the page (first non-full page
// for an allocate, the handle's page otherwise) and issues reads of that
// page's busy-bit row and of the slot's count; in the execute state it
// evaluates the request on the read data, writes the row and the count
// back and loads the result register. A new request is taken only
// once the previous one has written back, so one memory write port per store
// suffices and no forwarding is needed. The result register holds a finished
// result while the next request is taken; that request waits in the execute
// state until the result is taken. Counts live in a plain memory that needs no
// clearing after reset: a slot's count is read as zero unless its busy bit is
// set. Busy rows carry one valid bit per page, and per-page full flags steer
// allocation, so reset is immediate and there is no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator_unit #(
    parameter int SLOTS_PER_PAGE = rcsa_pkg::SLOTS_PER_PAGE_DEF,
    parameter int PAGES          = rcsa_pkg::PAGES_DEF,
    parameter int COUNT_BITS     = rcsa_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [6:0] slot_handle,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] granted_slot,
    output logic [1:0] status,
    output logic       released,
    output logic [7:0] ref_count,
    output logic [7:0] used_slots
);

    localparam int TOTAL   = SLOTS_PER_PAGE * PAGES;
    localparam int SLOT_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int OFF_W   = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int TOT_W   = $clog2(TOTAL + 1);
    localparam int HANDLES = 128;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic { S_IDLE, S_EXEC } state_t;

    // ------------------------------------------------------------------
    // Storage: busy-bit rows per page, counts per slot
    // ------------------------------------------------------------------
    logic [SLOTS_PER_PAGE-1:0] row_mem [PAGES];
    logic [COUNT_BITS-1:0]     refs_mem [TOTAL];

    // handle to page and offset, worked out at elaboration
    logic [PAGE_W-1:0] page_lut [HANDLES];
    logic [OFF_W-1:0]  off_lut  [HANDLES];

    for (genvar i = 0; i < HANDLES; i++)
    begin : g_lut
        assign page_lut[i] = PAGE_W'(i / SLOTS_PER_PAGE);
        assign off_lut[i]  = OFF_W'(i % SLOTS_PER_PAGE);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [1:0]          req_reg;
    logic [6:0]          handle_reg;
    logic                in_pool_reg;
    logic                pool_full_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                row_hit_reg;
    logic [SLOTS_PER_PAGE-1:0] row_rd_reg;
    logic [COUNT_BITS-1:0]     refs_rd_reg;

    logic [PAGES-1:0]    page_full_reg, page_full_next;
    logic [PAGES-1:0]    row_valid_reg, row_valid_next;
    logic [TOT_W-1:0]    total_reg, total_next;

    logic                out_valid_reg, out_valid_next;
    logic [6:0]          granted_reg, granted_next;
    logic [1:0]          status_reg, status_next;
    logic                released_reg, released_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          used_reg, used_next;

    // ------------------------------------------------------------------
    // Accept cycle: choose page and slot, issue reads
    // ------------------------------------------------------------------
    logic              accept;
    logic              page_avail;
    logic [PAGE_W-1:0] alloc_page;
    logic              h_in_pool;
    logic [PAGE_W-1:0] issue_page;
    logic [OFF_W-1:0]  issue_off;
    logic [SLOT_W-1:0] issue_slot;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    rcsa_first_zero #(
        .W     (PAGES)
    ) u_page_pick (
        .bits  (page_full_reg),
        .found (page_avail),
        .index (alloc_page)
    );

    assign h_in_pool = 32'(slot_handle) < 32'(TOTAL);

    always_comb
    begin
        issue_off  = off_lut[slot_handle];
        issue_slot = SLOT_W'(slot_handle);
        if (req_type == rcsa_pkg::REQ_ALLOC)
        begin
            issue_page = alloc_page;
        end
        else if (h_in_pool)
        begin
            issue_page = page_lut[slot_handle];
        end
        else
        begin
            // keep reads inside the arrays; the result is gated anyway
            issue_page = '0;
            issue_slot = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg       <= req_type;
            handle_reg    <= slot_handle;
            in_pool_reg   <= h_in_pool;
            pool_full_reg <= !page_avail;
            page_reg      <= issue_page;
            off_reg       <= issue_off;
            slot_reg      <= issue_slot;
            row_hit_reg   <= row_valid_reg[issue_page];
            row_rd_reg    <= row_mem[issue_page];
            refs_rd_reg   <= refs_mem[issue_slot];
        end
    end

    // ------------------------------------------------------------------
    // Execute cycle: evaluate the request on read data, write back
    // ------------------------------------------------------------------
    logic [SLOTS_PER_PAGE-1:0] row_eff;
    logic [SLOTS_PER_PAGE-1:0] row_wdata;
    logic                      row_we;
    logic [COUNT_BITS-1:0]     ref_wdata;
    logic [SLOT_W-1:0]         ref_waddr;
    logic                      ref_we;
    logic                      slot_free;
    logic [OFF_W-1:0]          free_off;
    logic                      slot_busy;
    logic [COUNT_BITS-1:0]     cnt_cur;
    logic [COUNT_BITS-1:0]     cnt_dec;
    logic [SLOT_W-1:0]         alloc_slot;
    logic                      commit;

    // a page row never written reads as all free
    assign row_eff   = row_hit_reg ? row_rd_reg : '0;
    assign slot_busy = in_pool_reg && row_eff[off_reg];
    assign cnt_cur   = slot_busy ? refs_rd_reg : '0;
    assign cnt_dec   = cnt_cur - COUNT_BITS'(1);
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    rcsa_first_zero #(
        .W     (SLOTS_PER_PAGE)
    ) u_slot_pick (
        .bits  (row_eff),
        .found (slot_free),
        .index (free_off)
    );

    assign alloc_slot = SLOT_W'(32'(page_reg) * 32'(SLOTS_PER_PAGE) + 32'(free_off));

    always_comb
    begin
        state_next     = state_reg;
        page_full_next = page_full_reg;
        row_valid_next = row_valid_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        released_next  = released_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        row_we         = 1'b0;
        row_wdata      = row_eff;
        ref_we         = 1'b0;
        ref_waddr      = slot_reg;
        ref_wdata      = cnt_cur;

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    logic [COUNT_BITS-1:0] cnt_out;
                    logic [TOT_W-1:0]      tot_out;
                    logic [6:0]            slot_out;
                    cnt_out       = cnt_cur;
                    tot_out       = total_reg;
                    slot_out      = handle_reg;
                    status_next   = rcsa_pkg::ST_OK;
                    released_next = 1'b0;

                    case (req_reg)
                        rcsa_pkg::REQ_ALLOC:
                        begin
                            if (pool_full_reg || !slot_free)
                            begin
                                status_next = rcsa_pkg::ST_FULL;
                                slot_out    = '0;
                                cnt_out     = '0;
                            end
                            else
                            begin
                                row_wdata[free_off]      = 1'b1;
                                row_we                   = 1'b1;
                                row_valid_next[page_reg] = 1'b1;
                                page_full_next[page_reg] = &row_wdata;
                                ref_we                   = 1'b1;
                                ref_waddr                = alloc_slot;
                                ref_wdata                = COUNT_BITS'(1);
                                tot_out                  = total_reg + TOT_W'(1);
                                slot_out                 = 7'(32'(alloc_slot));
                                cnt_out                  = COUNT_BITS'(1);
                            end
                        end
                        rcsa_pkg::REQ_ADD:
                        begin
                            if (!slot_busy)
                            begin
                                status_next = rcsa_pkg::ST_NOT_BUSY;
                                cnt_out     = '0;
                            end
                            else if (cnt_cur == CNT_MAX)
                            begin
                                status_next = rcsa_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                ref_we    = 1'b1;
                                ref_wdata = cnt_cur + COUNT_BITS'(1);
                                cnt_out   = cnt_cur + COUNT_BITS'(1);
                            end
                        end
                        rcsa_pkg::REQ_DROP:
                        begin
                            if (!slot_busy)
                            begin
                                status_next = rcsa_pkg::ST_NOT_BUSY;
                                cnt_out     = '0;
                            end
                            else
                            begin
                                ref_we    = 1'b1;
                                ref_wdata = cnt_dec;
                                cnt_out   = cnt_dec;
                                if (cnt_dec == '0)
                                begin
                                    // last reference gone: free the slot
                                    row_wdata[off_reg]       = 1'b0;
                                    row_we                   = 1'b1;
                                    page_full_next[page_reg] = 1'b0;
                                    tot_out                  = total_reg - TOT_W'(1);
                                    released_next            = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // unknown request: report the current count only
                        end
                    endcase

                    total_next     = tot_out;
                    granted_next   = slot_out;
                    count_next     = 8'(32'(cnt_out));
                    used_next      = 8'(32'(tot_out));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            page_full_reg <= '0;
            row_valid_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            page_full_reg <= page_full_next;
            row_valid_reg <= row_valid_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        granted_reg  <= granted_next;
        status_reg   <= status_next;
        released_reg <= released_next;
        count_reg    <= count_next;
        used_reg     <= used_next;
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[page_reg] <= row_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            refs_mem[ref_waddr] <= ref_wdata;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;
    assign released     = released_reg;
    assign ref_count    = count_reg;
    assign used_slots   = used_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(TOTAL))
        else $error("busy slot total exceeds pool size");

    a_full_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
        (page_full_reg & ~row_valid_reg) == '0)
        else $error("page marked full without a written busy row");

    a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && released |-> status == rcsa_pkg::ST_OK && ref_count == 8'd0)
        else $error("release reported with nonzero count or error status");

    a_full_is_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rcsa_pkg::ST_FULL |-> &page_full_reg)
        else $error("pool full reported while a page has a free slot");
`endif

endmodule
